[src/grouped_bitmap_block_allocator_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define GBBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define GBBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

[src/gbba_pkg.sv]
// Shared types and constants of the grouped bitmap block allocator.
package gbba_pkg;

  localparam int unsigned BLK_W = 15;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  localparam logic REG_TOTAL_BLOCKS     = 1'b0;
  localparam logic REG_FIRST_DATA_BLOCK = 1'b1;

  localparam logic [BLK_W-1:0] TOTAL_BLOCKS_RESET = 15'd16384;

  typedef struct packed {
    logic             opcode;
    logic [BLK_W-1:0] block_number;
  } in_t;

  typedef struct packed {
    logic [BLK_W-1:0] allocated_block;
    logic [1:0]       status;
    logic [BLK_W-1:0] free_total;
  } out_t;

endpackage

[src/gbba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/grouped_bitmap_block_allocator.sv]
// Top level of the grouped first-fit bitmap block allocator.
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  -------------------------------------
//  in        input      in_valid_i/in_ready_o   in_item_i  (opcode, block_number)
//  out       output     out_valid_o/out_ready_i out_item_o (allocated_block, status,
//                                               free_total)
//  config    input      psel/penable/pready     paddr, pwdata, prdata
//
//  After reset the block sweeps the bitmap RAM, one word per cycle, marking every
//  block used and zeroing the group counts, and no item is taken meanwhile. An
//  allocate reads the free count of each group in turn, skips groups whose count is
//  zero and reads the bitmap words of a group with free blocks one at a time through
//  the single bitmap read port. A free walks the group bounds one group at a time up
//  to the block's group, then reads the bitmap word and clears the block's bit if set.
//  The result sits in an output register; a stalled output holds the next result
//  in the sequencer until the register frees up.

`include "grouped_bitmap_block_allocator_macros.svh"

module grouped_bitmap_block_allocator import gbba_pkg::*; #(
  parameter int unsigned BLOCKS_PER_GROUP = 1024,
  parameter int unsigned NUM_GROUPS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_item_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_item_o,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sizes derived from the geometry.
  localparam int unsigned TOTAL_BITS = NUM_GROUPS * BLOCKS_PER_GROUP;
  localparam int unsigned WORDS      = (TOTAL_BITS + 63) / 64;
  localparam int unsigned WA_W       = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int unsigned GA_W       = NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned G_W        = $clog2(NUM_GROUPS + 1);
  localparam int unsigned CNT_W      = $clog2(BLOCKS_PER_GROUP + 1);
  localparam int unsigned TOT_W      = $clog2(TOTAL_BITS + 1);
  localparam int unsigned P_W        = $clog2((NUM_GROUPS + 1) * BLOCKS_PER_GROUP + 64);
  localparam int unsigned X_W        = P_W > BLK_W ? P_W : BLK_W;
  localparam int unsigned CL_W       = $clog2(WORDS + 1);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_GRP_RD   = 10'b0000000100,
    S_GRP_CHK  = 10'b0000001000,
    S_WRD_RD   = 10'b0000010000,
    S_WRD_CHK  = 10'b0000100000,
    S_FREE_GRP = 10'b0001000000,
    S_FREE_RD  = 10'b0010000000,
    S_FREE_CHK = 10'b0100000000,
    S_RESULT   = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [G_W-1:0]     g_q, g_d;
  logic [P_W-1:0]     base_q, base_d;
  logic [P_W-1:0]     p_q, p_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [1:0]         st_q, st_d;
  logic [CL_W-1:0]    clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;
  logic [BLK_W-1:0]   total_blocks_q;
  logic               fdb_q;

  // RAM ports.
  logic               word_we, cnt_we;
  logic [WA_W-1:0]    word_waddr, word_raddr;
  logic [63:0]        word_wdata, word_rdata;
  logic [GA_W-1:0]    cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;

  // Datapath around the scan position.
  logic [P_W-1:0]     group_end, word_base, span, next_word, alloc_pos;
  logic [63:0]        mask, cand, bit_sel;
  logic               hit;
  logic [5:0]         hit_idx;
  logic               base_past_total, g_past_end;
  logic               free_hit;
  logic [BLK_W-1:0]   rel;
  logic               free_bad;

  // Register port: writes land in the access phase; low address bits are not decoded.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIRST_DATA_BLOCK) ? {31'd0, fdb_q}
                                                      : {{(32 - BLK_W){1'b0}}, total_blocks_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q <= TOTAL_BLOCKS_RESET;
      fdb_q          <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TOTAL_BLOCKS) begin
        total_blocks_q <= pwdata[BLK_W-1:0];
      end else begin
        fdb_q <= pwdata[0];
      end
    end
  end

  // Bitmap and per-group free counts live in RAM.
  gbba_ram #(.WIDTH(64), .DEPTH(WORDS)) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (word_wdata),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  gbba_ram #(.WIDTH(CNT_W), .DEPTH(NUM_GROUPS)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign word_raddr = p_q[6 +: WA_W];
  assign cnt_raddr  = g_q[GA_W-1:0];

  // The scan covers one 64-bit word per step, limited to the current group.
  assign group_end       = base_q + P_W'(BLOCKS_PER_GROUP);
  assign word_base       = {p_q[P_W-1:6], 6'd0};
  assign span            = group_end - word_base;
  assign next_word       = word_base + P_W'(64);
  assign base_past_total = X_W'(base_q) >= X_W'(total_blocks_q);
  assign g_past_end      = g_q >= G_W'(NUM_GROUPS);

  always_comb begin
    for (int k = 0; k < 64; k++) begin
      mask[k] = (6'(k) >= p_q[5:0]) && (P_W'(k) < span);
    end
  end

  assign cand = ~word_rdata & mask;
  assign hit  = |cand;

  // Lowest clear bit of the masked word.
  always_comb begin
    hit_idx = 6'd0;
    for (int k = 63; k >= 0; k--) begin
      if (cand[k]) begin
        hit_idx = 6'(k);
      end
    end
  end

  assign alloc_pos = word_base + P_W'(hit_idx);
  assign bit_sel   = 64'd1 << p_q[5:0];
  assign free_hit  = (state_q == S_FREE_CHK) && word_rdata[p_q[5:0]];

  // Range checks on a free request, done at acceptance.
  assign rel      = in_item_i.block_number - BLK_W'(fdb_q);
  assign free_bad = (in_item_i.block_number == '0)
                 || (in_item_i.block_number >= total_blocks_q)
                 || (in_item_i.block_number < BLK_W'(fdb_q))
                 || (X_W'(rel) >= X_W'(TOTAL_BITS));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    g_d         = g_q;
    base_d      = base_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    blk_d       = blk_q;
    st_d        = st_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    word_we     = 1'b0;
    word_waddr  = word_raddr;
    word_wdata  = word_rdata;
    cnt_we      = 1'b0;
    cnt_waddr   = g_q[GA_W-1:0];
    cnt_wdata   = cnt_rdata;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        // Mark every block used and zero the group counts after reset.
        word_we    = 1'b1;
        word_waddr = clr_q[WA_W-1:0];
        word_wdata = '1;
        if (clr_q < CL_W'(NUM_GROUPS)) begin
          cnt_we    = 1'b1;
          cnt_waddr = clr_q[GA_W-1:0];
          cnt_wdata = '0;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CL_W'(WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          g_d    = '0;
          base_d = '0;
          blk_d  = '0;
          if (in_item_i.opcode == OP_ALLOC) begin
            state_d = S_GRP_RD;
          end else if (free_bad) begin
            st_d    = STATUS_IGNORED;
            state_d = S_RESULT;
          end else begin
            p_d     = P_W'(rel);
            state_d = S_FREE_GRP;
          end
        end
      end
      S_GRP_RD: begin
        if (g_past_end || base_past_total) begin
          st_d    = STATUS_NO_FREE;
          state_d = S_RESULT;
        end else begin
          state_d = S_GRP_CHK;
        end
      end
      S_GRP_CHK: begin
        cnt_d = cnt_rdata;
        if (cnt_rdata == '0) begin
          g_d     = g_q + 1'b1;
          base_d  = group_end;
          state_d = S_GRP_RD;
        end else begin
          p_d     = base_q;
          state_d = S_WRD_RD;
        end
      end
      S_WRD_RD: begin
        state_d = S_WRD_CHK;
      end
      S_WRD_CHK: begin
        if (hit) begin
          word_we    = 1'b1;
          word_wdata = word_rdata | (64'd1 << hit_idx);
          cnt_we     = 1'b1;
          cnt_wdata  = cnt_q - 1'b1;
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
          blk_d   = BLK_W'(X_W'(alloc_pos) + X_W'(fdb_q));
          st_d    = STATUS_DONE;
          state_d = S_RESULT;
        end else if (next_word >= group_end) begin
          // Count said free but no clear bit: move on to the next group.
          g_d     = g_q + 1'b1;
          base_d  = group_end;
          state_d = S_GRP_RD;
        end else begin
          p_d     = next_word;
          state_d = S_WRD_RD;
        end
      end
      S_FREE_GRP: begin
        // Walk the group bounds until the block's group is found.
        if (p_q < group_end) begin
          state_d = S_FREE_RD;
        end else begin
          g_d    = g_q + 1'b1;
          base_d = group_end;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (free_hit) begin
          word_we    = 1'b1;
          word_wdata = word_rdata & ~bit_sel;
          cnt_we     = 1'b1;
          cnt_wdata  = cnt_rdata + 1'b1;
          total_d    = total_q + 1'b1;
          st_d       = STATUS_DONE;
        end else begin
          st_d = STATUS_IGNORED;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.allocated_block = blk_q;
          out_d.status          = st_q;
          out_d.free_total      = BLK_W'(total_q);
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q    <= g_d;
    base_q <= base_d;
    p_q    <= p_d;
    cnt_q  <= cnt_d;
    blk_q  <= blk_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An accepted item keeps the sequencer busy on the following cycle.
  `GBBA_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)
  // A word examined by an allocate scan always starts inside the current group.
  `GBBA_ASSERT_IMPL(a_scan_in_group, state_q == S_WRD_CHK, p_q < group_end && p_q >= base_q)
  // A successful free raises the total count by exactly one.
  `GBBA_ASSERT_NEXT(a_free_counts, free_hit, total_q == $past(total_q) + TOT_W'(1))

endmodule

[sim/grouped_bitmap_block_allocator_test.sv]
// Self-checking testbench for the grouped first-fit bitmap block allocator.
`timescale 1ns / 100ps

module grouped_bitmap_block_allocator_test;
  import gbba_pkg::*;

  localparam int unsigned BPG   = 1024;
  localparam int unsigned NGRP  = 16;
  localparam int unsigned NBITS = BPG * NGRP;

  // Clock, reset and the pins of the block. Every input starts at a known value.
  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready_o;
  in_t         in_item    = '0;
  logic        out_valid_o;
  logic        out_ready  = 1'b0;
  out_t        out_item_o;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  // Requests waiting to be offered, and the outcomes predicted for requests
  // the block has already taken, oldest first.
  in_t  request_queue[$];
  out_t outcome_queue[$];

  // Shadow of the allocator: bitmap, group counts, total count and registers.
  bit          block_used [NBITS];
  int unsigned group_free [NGRP];
  int unsigned free_blocks  = 0;
  int unsigned volume_size  = 16384;
  int unsigned first_block  = 0;

  bit          failed       = 1'b0;
  bit          calm_tail    = 1'b0;
  int unsigned send_idle    = 0;
  int unsigned recv_idle    = 0;
  int unsigned results_seen = 0;
  bit          long_hold_done = 1'b0;
  out_t        oldest;

  grouped_bitmap_block_allocator #(
    .BLOCKS_PER_GROUP(BPG),
    .NUM_GROUPS      (NGRP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 2 ns clock period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Applies one request to the shadow allocator and returns the outcome the
  // block must report for it.
  function automatic out_t predict_outcome(in_t req);
    out_t        res;
    int unsigned groups;
    int unsigned pos;
    int unsigned rel;
    int unsigned grp;
    bit          found;
    res    = '0;
    found  = 1'b0;
    if (req.opcode == OP_ALLOC) begin
      // First fit: only the active groups are scanned, and groups whose count
      // is zero are skipped without looking at their bits.
      groups = (volume_size + BPG - 1) / BPG;
      if (groups > NGRP) groups = NGRP;
      res.status = STATUS_NO_FREE;
      for (int unsigned g = 0; g < groups && !found; g++) begin
        if (group_free[g] != 0) begin
          for (int unsigned i = 0; i < BPG && !found; i++) begin
            pos = g * BPG + i;
            if (!block_used[pos]) begin
              found           = 1'b1;
              block_used[pos] = 1'b1;
              group_free[g]--;
              if (free_blocks > 0) free_blocks--;
              res.allocated_block = BLK_W'(first_block + pos);
              res.status          = STATUS_DONE;
            end
          end
        end
      end
    end else begin
      // Block zero, blocks outside the volume, blocks below the first data
      // block, blocks past the last group and blocks already free are ignored.
      res.status = STATUS_IGNORED;
      if (req.block_number != 0 && req.block_number < volume_size &&
          req.block_number >= first_block) begin
        rel = req.block_number - first_block;
        grp = rel / BPG;
        if (grp < NGRP && block_used[rel]) begin
          block_used[rel] = 1'b0;
          group_free[grp]++;
          free_blocks++;
          res.status = STATUS_DONE;
        end
      end
    end
    res.free_total = BLK_W'(free_blocks);
    return res;
  endfunction

  // Sender. A request is predicted at the edge where its transfer happens,
  // which keeps the shadow in step with the block's own order of work.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        outcome_queue.push_back(predict_outcome(in_item));
      end
      // A new request may be placed only once the current one has gone.
      if (!in_valid || in_ready_o) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0 && !calm_tail &&
                     $urandom_range(0, 5) == 0) begin
          // Start a random idle burst, this cycle included.
          send_idle = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          in_item  <= request_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (outcome_queue.size() == 0) begin
          $display("%0t: result with nothing predicted: block %0d status %0d free %0d",
                   $time, out_item_o.allocated_block, out_item_o.status,
                   out_item_o.free_total);
          failed = 1'b1;
        end else begin
          oldest = outcome_queue.pop_front();
          if (out_item_o.allocated_block !== oldest.allocated_block) begin
            $display("%0t: allocated_block expected %0d actual %0d", $time,
                     oldest.allocated_block, out_item_o.allocated_block);
            failed = 1'b1;
          end
          if (out_item_o.status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     oldest.status, out_item_o.status);
            failed = 1'b1;
          end
          if (out_item_o.free_total !== oldest.free_total) begin
            $display("%0t: free_total expected %0d actual %0d", $time,
                     oldest.free_total, out_item_o.free_total);
            failed = 1'b1;
          end
        end
      end
      // Once in the run, hold off for a long stretch so that the output
      // register and the sequencer fill and the input side has to stall.
      if (!long_hold_done && results_seen == 200) begin
        long_hold_done = 1'b1;
        recv_idle      = 400;
      end
      if (recv_idle > 0) begin
        recv_idle--;
        out_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        recv_idle = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_req(logic op, int unsigned blk);
    in_t req;
    req.opcode       = op;
    req.block_number = blk[BLK_W-1:0];
    request_queue.push_back(req);
  endfunction

  // Returns once every request has gone in and every result has come out,
  // then lets the clock run on so the block is surely back at rest.
  task automatic wait_idle();
    while (request_queue.size() != 0 || in_valid || outcome_queue.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write: a setup phase, then an access phase that ends at the edge
  // where pready is seen high.
  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TOTAL_BLOCKS) volume_size = val & 32'h7fff;
    else first_block = val & 32'h1;
  endtask

  task automatic program_volume(int unsigned blocks, int unsigned first);
    reg_write(REG_TOTAL_BLOCKS, blocks);
    reg_write(REG_FIRST_DATA_BLOCK, first);
  endtask

  // Random traffic. Frees mostly land in a window that moves now and then, so
  // blocks are freed, allocated again and sometimes freed twice; a tenth of
  // the requests are frees of arbitrary 15-bit block numbers.
  task automatic fill_phase(int unsigned count, int unsigned vol);
    int unsigned base;
    int unsigned span;
    int unsigned pick;
    base = 0;
    span = 16;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 25 == 0) begin
        base = $urandom_range(0, vol);
        span = $urandom_range(16, (vol < 600) ? vol + 16 : 600);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) queue_req(OP_ALLOC, $urandom_range(0, 32767));
      else if (pick < 9) queue_req(OP_FREE, base + $urandom_range(0, span));
      else queue_req(OP_FREE, $urandom_range(0, 32767));
    end
  endtask

  initial begin
    int unsigned vol;
    // After reset every block is marked used and every count is zero.
    foreach (block_used[k]) block_used[k] = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset settings. The block marks its whole bitmap
    // used after reset; the sender simply waits for ready meanwhile.
    queue_req(OP_ALLOC, 0);       // nothing freed yet: no free block
    queue_req(OP_FREE, 0);        // block zero is never freed
    queue_req(OP_FREE, 16384);    // one past the volume
    queue_req(OP_FREE, 32767);    // all ones
    queue_req(OP_FREE, 1);
    queue_req(OP_FREE, 1);        // double free
    queue_req(OP_FREE, 1023);     // last block of group zero
    queue_req(OP_FREE, 1024);     // first block of group one
    queue_req(OP_FREE, 16383);    // last block of the last group
    repeat (4) queue_req(OP_ALLOC, 32767);
    queue_req(OP_ALLOC, 0);       // drained again
    wait_idle();

    // Offset volume larger than the bitmap: block numbers that map past the
    // last group must be ignored.
    program_volume(32767, 1);
    queue_req(OP_FREE, 0);
    queue_req(OP_FREE, 1);        // bit 0 of group zero
    queue_req(OP_FREE, 16385);    // maps to a group beyond the last one
    queue_req(OP_FREE, 16384);    // last bit of the bitmap
    queue_req(OP_FREE, 3100);
    wait_idle();

    // Shrunk volume: only group zero is scanned, the other free blocks stay.
    program_volume(1024, 1);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 3100);     // now outside the volume
    wait_idle();

    // Empty volume: nothing is scanned and nothing can be freed.
    program_volume(0, 1);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 1);
    wait_idle();

    // Back to the full volume; the first kept block in the upper groups is found again.
    program_volume(16384, 0);
    queue_req(OP_ALLOC, 0);
    wait_idle();

    // Random part over a range of volume settings, tiny volumes among them so
    // that allocation runs dry often.
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0, 4:    vol = 16384;
        1:       vol = $urandom_range(1, 16384);
        2:       vol = $urandom_range(1, 200);
        default: vol = $urandom_range(1000, 3000);
      endcase
      program_volume(vol, $urandom_range(0, 1));
      fill_phase(100, vol);
      wait_idle();
    end

    // Closing stretch at full rate on both sides.
    calm_tail = 1'b1;
    program_volume(16384, 0);
    fill_phase(80, 16384);
    wait_idle();

    // A late stray result would still be caught by the receiver here.
    repeat (200) @(posedge clk_i);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog. The slowest legal run is about 900 transfers, each at its slowest
  // when every allocate scans all groups and both sides stall hardest, plus
  // the clearing sweep and the long hold; the limit leaves ample margin.
  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
